// ===== rtl/core/aik_pkg.sv =====
`timescale 1ns / 1ps

package aik_pkg;

  localparam int CordicStagesDef = 16;
  localparam int JointW = 17;
  localparam int OpW = 48;
  localparam int SqW = 64;
  localparam int SqSteps = SqW / 2;
  localparam int NormSteps = 10;
  localparam int FineW = 34;

  localparam logic signed [31:0] Deg180Fine = 32'sd754974720;
  localparam logic signed [FineW-1:0] AngLimit = 34'sd46080;
  localparam logic signed [JointW-1:0] PitchFixed = -17'sd5760;

  typedef enum logic [1:0] {
    REG_UPPER = 2'd0,
    REG_FORE  = 2'd1,
    REG_BASE  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic               valid;
    logic signed [14:0] x;
    logic signed [14:0] y;
    logic signed [15:0] s;
    logic signed [31:0] n;
    logic [28:0]        d;
    logic               le;
    logic signed [14:0] roll;
  } sq_side_t;

  typedef struct packed {
    logic valid;
    logic signed [14:0] roll;
  } at_side_t;

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic zero;
  } quad_t;

  // arctan(2^-i) in 2^-22 degree
  function automatic logic signed [31:0] atan_fine(input int i);
    logic signed [31:0] v;
    case (i)
      0: v = 32'sd188743680;
      1: v = 32'sd111421900;
      2: v = 32'sd58872272;
      3: v = 32'sd29884485;
      4: v = 32'sd15000234;
      5: v = 32'sd7507429;
      6: v = 32'sd3754631;
      7: v = 32'sd1877430;
      8: v = 32'sd938729;
      9: v = 32'sd469366;
      10: v = 32'sd234683;
      11: v = 32'sd117342;
      12: v = 32'sd58671;
      13: v = 32'sd29335;
      14: v = 32'sd14668;
      15: v = 32'sd7334;
      16: v = 32'sd3667;
      17: v = 32'sd1833;
      18: v = 32'sd917;
      19: v = 32'sd458;
      20: v = 32'sd229;
      21: v = 32'sd115;
      22: v = 32'sd57;
      23: v = 32'sd29;
      24: v = 32'sd14;
      25: v = 32'sd7;
      26: v = 32'sd4;
      27: v = 32'sd2;
      28: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/aik_delay.sv =====
`timescale 1ns / 1ps

module aik_delay import aik_pkg::*; #(
  parameter int W = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] d_o
);

  logic [W-1:0] line_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) line_q[i] <= '0;
    end else if (en_i) begin
      line_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) line_q[i] <= line_q[i-1];
    end
  end

  assign d_o = line_q[DEPTH-1];

endmodule

// ===== rtl/core/aik_sqrt_cell.sv =====
`timescale 1ns / 1ps

module aik_sqrt_cell import aik_pkg::*; #(
  parameter int K = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [SqW-1:0] rad_i,
  input  logic [SqW-1:0] res_i,
  output logic [SqW-1:0] rad_o,
  output logic [SqW-1:0] res_o
);

  localparam logic [SqW-1:0] Bit = SqW'(1) << (SqW - 2 - 2 * K);

  logic [SqW-1:0] sum;
  logic [SqW-1:0] rad_d, res_d, rad_q, res_q;

  always_comb begin
    sum = res_i + Bit;
    if (rad_i >= sum) begin
      rad_d = rad_i - sum;
      res_d = (res_i >> 1) + Bit;
    end else begin
      rad_d = rad_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q <= rad_d;
      res_q <= res_d;
    end
  end

  assign rad_o = rad_q;
  assign res_o = res_q;

endmodule

// ===== rtl/core/aik_cordic_cell.sv =====
`timescale 1ns / 1ps

module aik_cordic_cell import aik_pkg::*; #(
  parameter int I = 0
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [32:0] x_i,
  input  logic signed [32:0] y_i,
  input  logic signed [31:0] z_i,
  output logic signed [32:0] x_o,
  output logic signed [32:0] y_o,
  output logic signed [31:0] z_o
);

  localparam logic signed [31:0] Step = atan_fine(I);

  logic signed [32:0] dx, dy, x_d, y_d, x_q, y_q;
  logic signed [31:0] z_d, z_q;

  always_comb begin
    dx = y_i >>> I;
    dy = x_i >>> I;
    if (!y_i[32]) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + Step;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - Step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

// ===== rtl/core/aik_atan2.sv =====
`timescale 1ns / 1ps

module aik_atan2 import aik_pkg::*; #(
  parameter int STAGES = CordicStagesDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic signed [OpW-1:0] y_i,
  input  logic signed [OpW-1:0] x_i,
  output logic signed [31:0]    ang_o
);

  logic [OpW-1:0] mx, my;
  logic [OpW-1:0] nx_q [NormSteps+1];
  logic [OpW-1:0] ny_q [NormSteps+1];
  logic [OpW-1:0] nm_q [NormSteps+1];
  quad_t quad_in, quad_q, quad_out;

  logic signed [32:0] cx [STAGES+1];
  logic signed [32:0] cy [STAGES+1];
  logic signed [31:0] cz [STAGES+1];
  logic signed [31:0] ang_d, ang_q;

  assign mx = x_i[OpW-1] ? OpW'(-x_i) : OpW'(x_i);
  assign my = y_i[OpW-1] ? OpW'(-y_i) : OpW'(y_i);
  assign quad_in = '{xneg: x_i[OpW-1], yneg: y_i[OpW-1],
                     zero: (x_i == '0) && (y_i == '0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_q <= '0;
    end else if (en_i) begin
      quad_q <= quad_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q[0] <= mx;
      ny_q[0] <= my;
      nm_q[0] <= (mx > my) ? mx : my;
    end
  end

  // bring the larger magnitude into [2^29, 2^30): right steps, then left steps
  for (genvar j = 0; j < NormSteps; j++) begin : g_norm
    localparam int S = (j < 5) ? (16 >> j) : (16 >> (j - 5));
    logic take;
    if (j < 5) begin : g_right
      assign take = nm_q[j] >= (OpW'(1) << (29 + S));
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          nx_q[j+1] <= take ? (nx_q[j] >> S) : nx_q[j];
          ny_q[j+1] <= take ? (ny_q[j] >> S) : ny_q[j];
          nm_q[j+1] <= take ? (nm_q[j] >> S) : nm_q[j];
        end
      end
    end else begin : g_left
      assign take = nm_q[j] < (OpW'(1) << (30 - S));
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          nx_q[j+1] <= take ? (nx_q[j] << S) : nx_q[j];
          ny_q[j+1] <= take ? (ny_q[j] << S) : ny_q[j];
          nm_q[j+1] <= take ? (nm_q[j] << S) : nm_q[j];
        end
      end
    end
  end

  assign cx[0] = $signed({3'b000, nx_q[NormSteps][29:0]});
  assign cy[0] = $signed({3'b000, ny_q[NormSteps][29:0]});
  assign cz[0] = '0;

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    aik_cordic_cell #(.I(i)) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .x_i   (cx[i]),
      .y_i   (cy[i]),
      .z_i   (cz[i]),
      .x_o   (cx[i+1]),
      .y_o   (cy[i+1]),
      .z_o   (cz[i+1])
    );
  end

  aik_delay #(.W($bits(quad_t)), .DEPTH(NormSteps + STAGES)) u_quad (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .d_i    (quad_q),
    .d_o    (quad_out)
  );

  always_comb begin
    ang_d = quad_out.xneg ? (Deg180Fine - cz[STAGES]) : cz[STAGES];
    if (quad_out.yneg) ang_d = -ang_d;
    if (quad_out.zero) ang_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) ang_q <= ang_d;
  end

  assign ang_o = ang_q;

endmodule

// ===== rtl/core/arm_inverse_kinematics.sv =====
`timescale 1ns / 1ps

// Elbow-down inverse kinematics for a five-joint arm, fully pipelined: one
// target word may enter every cycle and each gives exactly one word of
// five joint angles (1/64 degree, saturated to +-720 degrees). Its depth
// is set by the 32-cell square-root chains and the per-angle chain of 10
// normalize cells and CORDIC_STAGES rotation cells. Words leave in order.
// When the output word is held by out_stall_i the whole pipeline holds
// and in_stall_o is raised. Link lengths and base height go through the
// cfg port (index 0 upper link, 1 fore link, 2 base height, 3 ignored);
// the user must write them only while the block is idle (not enforced).

module arm_inverse_kinematics import aik_pkg::*; #(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [14:0]       target_x_i,
  input  logic signed [14:0]       target_y_i,
  input  logic signed [14:0]       target_z_i,
  input  logic signed [14:0]       roll_angle_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [JointW-1:0] base_joint_o,
  output logic signed [JointW-1:0] shoulder_joint_o,
  output logic signed [JointW-1:0] elbow_joint_o,
  output logic signed [JointW-1:0] pitch_joint_o,
  output logic signed [JointW-1:0] roll_joint_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [13:0]              cfg_data_i
);

  localparam int AtLat = NormSteps + CORDIC_STAGES + 2;

  function automatic logic signed [JointW-1:0] to_out(input logic signed [FineW-1:0] f);
    logic signed [FineW-1:0] v;
    v = (f + FineW'(32768)) >>> 16;
    if (v > AngLimit) v = AngLimit;
    if (v < -AngLimit) v = -AngLimit;
    return v[JointW-1:0];
  endfunction

  logic en;
  logic [13:0] a2_q, a3_q, bh_q;

  // config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a2_q <= 14'd4064;
      a3_q <= 14'd4064;
      bh_q <= 14'd4064;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_UPPER: a2_q <= cfg_data_i;
        REG_FORE:  a3_q <= cfg_data_i;
        REG_BASE:  bh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // valid bits of the front and back stages
  logic va_q, vb_q, vc_q, vd_q, ve_q, vf_q, vg_q, vh_q, vi_q;
  sq_side_t side_e, side_f;
  at_side_t at_g, at_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0; vb_q <= 1'b0; vc_q <= 1'b0; vd_q <= 1'b0; ve_q <= 1'b0;
      vf_q <= 1'b0; vg_q <= 1'b0; vh_q <= 1'b0; vi_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
      vf_q <= side_f.valid;
      vg_q <= vf_q;
      vh_q <= at_h.valid;
      vi_q <= vh_q;
    end
  end

  // stage a: capture, shoulder-relative height
  logic signed [14:0] xa_q, ya_q, rolla_q;
  logic signed [15:0] sa_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      xa_q    <= target_x_i;
      ya_q    <= target_y_i;
      rolla_q <= roll_angle_i;
      sa_q    <= $signed({target_z_i[14], target_z_i}) - $signed({2'b00, bh_q});
    end
  end

  // stage b: squares
  logic signed [29:0] px, py;
  logic signed [31:0] ps;
  logic [28:0] xx_q, yy_q;
  logic [29:0] ss_q;
  logic [27:0] a22_q, a33_q, a23_q;
  logic signed [14:0] xb_q, yb_q, rollb_q;
  logic signed [15:0] sb_q;
  assign px = xa_q * xa_q;
  assign py = ya_q * ya_q;
  assign ps = sa_q * sa_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      xx_q  <= px[28:0];
      yy_q  <= py[28:0];
      ss_q  <= ps[29:0];
      a22_q <= a2_q * a2_q;
      a33_q <= a3_q * a3_q;
      a23_q <= a2_q * a3_q;
      xb_q <= xa_q; yb_q <= ya_q; sb_q <= sa_q; rollb_q <= rolla_q;
    end
  end

  // stage c: cosine-law numerator and denominator
  logic [29:0] rr_c;
  logic [29:0] rr_q;
  logic signed [31:0] n_q;
  logic [28:0] d_q;
  logic signed [14:0] xc_q, yc_q, rollc_q;
  logic signed [15:0] sc_q;
  assign rr_c = {1'b0, xx_q} + {1'b0, yy_q};
  always_ff @(posedge clk_i) begin
    if (en) begin
      rr_q <= rr_c;
      n_q  <= $signed({2'b00, rr_c}) + $signed({2'b00, ss_q})
              - $signed({4'b0000, a22_q}) - $signed({4'b0000, a33_q});
      d_q  <= {a23_q, 1'b0};
      xc_q <= xb_q; yc_q <= yb_q; sc_q <= sb_q; rollc_q <= rollb_q;
    end
  end

  // stage d: n^2 and d^2
  logic signed [31:0] nneg;
  logic [30:0] nabs;
  logic [30:0] nabs_q;
  logic [61:0] nsq_q;
  logic [57:0] dsq_q;
  logic [29:0] rrd_q;
  logic signed [31:0] nd_q;
  logic [28:0] dd_q;
  logic signed [14:0] xd_q, yd_q, rolld_q;
  logic signed [15:0] sd_q;
  assign nneg = -n_q;
  assign nabs = n_q[31] ? nneg[30:0] : n_q[30:0];
  always_ff @(posedge clk_i) begin
    if (en) begin
      nabs_q <= nabs;
      nsq_q  <= nabs * nabs;
      dsq_q  <= d_q * d_q;
      rrd_q <= rr_q; nd_q <= n_q; dd_q <= d_q;
      xd_q <= xc_q; yd_q <= yc_q; sd_q <= sc_q; rolld_q <= rollc_q;
    end
  end

  // stage e: radicands
  logic [SqW-1:0] radq_q, radh_q, radr_q;
  logic le_e;
  logic le_q;
  logic signed [31:0] ne_q;
  logic [28:0] de_q;
  logic signed [14:0] xe_q, ye_q, rolle_q;
  logic signed [15:0] se_q;
  assign le_e = {1'b0, nabs_q} <= {3'b000, dd_q};
  always_ff @(posedge clk_i) begin
    if (en) begin
      le_q   <= le_e;
      radq_q <= le_e ? ({6'd0, dsq_q} - {2'b00, nsq_q}) : ({2'b00, nsq_q} - {6'd0, dsq_q});
      radh_q <= {1'b0, nsq_q, 1'b0} - {6'd0, dsq_q};
      radr_q <= {34'd0, rrd_q};
      ne_q <= nd_q; de_q <= dd_q;
      xe_q <= xd_q; ye_q <= yd_q; se_q <= sd_q; rolle_q <= rolld_q;
    end
  end

  assign side_e = '{valid: ve_q, x: xe_q, y: ye_q, s: se_q, n: ne_q, d: de_q,
                    le: le_q, roll: rolle_q};

  // square-root chains
  logic [SqW-1:0] qv [SqSteps+1];
  logic [SqW-1:0] qr [SqSteps+1];
  logic [SqW-1:0] hv [SqSteps+1];
  logic [SqW-1:0] hr [SqSteps+1];
  logic [SqW-1:0] rv [SqSteps+1];
  logic [SqW-1:0] rr2 [SqSteps+1];
  assign qv[0] = radq_q; assign qr[0] = '0;
  assign hv[0] = radh_q; assign hr[0] = '0;
  assign rv[0] = radr_q; assign rr2[0] = '0;

  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    aik_sqrt_cell #(.K(k)) u_q (
      .clk_i(clk_i), .en_i(en), .rad_i(qv[k]), .res_i(qr[k]),
      .rad_o(qv[k+1]), .res_o(qr[k+1])
    );
    aik_sqrt_cell #(.K(k)) u_h (
      .clk_i(clk_i), .en_i(en), .rad_i(hv[k]), .res_i(hr[k]),
      .rad_o(hv[k+1]), .res_o(hr[k+1])
    );
    aik_sqrt_cell #(.K(k)) u_r (
      .clk_i(clk_i), .en_i(en), .rad_i(rv[k]), .res_i(rr2[k]),
      .rad_o(rv[k+1]), .res_o(rr2[k+1])
    );
  end

  aik_delay #(.W($bits(sq_side_t)), .DEPTH(SqSteps)) u_sq_side (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .d_i(side_e), .d_o(side_f)
  );

  // stage f: link products
  logic [31:0] q_f, h_f;
  logic [45:0] a3q_q, a2h_q;
  logic signed [46:0] a3n_q;
  logic [31:0] qf_q;
  logic [15:0] rf_q;
  logic signed [31:0] nf_q;
  logic signed [14:0] xf_q, yf_q, rollf_q;
  logic signed [15:0] sf_q;
  assign q_f = qr[SqSteps][31:0];
  assign h_f = side_f.le ? {3'b000, side_f.d} : hr[SqSteps][31:0];
  always_ff @(posedge clk_i) begin
    if (en) begin
      a3q_q <= a3_q * q_f;
      a2h_q <= a2_q * h_f;
      a3n_q <= $signed({1'b0, a3_q}) * side_f.n;
      qf_q  <= q_f;
      rf_q  <= rr2[SqSteps][15:0];
      nf_q  <= side_f.n;
      xf_q <= side_f.x; yf_q <= side_f.y; sf_q <= side_f.s; rollf_q <= side_f.roll;
    end
  end

  // stage g: angle operands
  logic signed [OpW-1:0] y1_q, x1_q, y3_q, x3_q, ya2_q, xa2_q, yb2_q, xb2_q;
  logic signed [14:0] rollg_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      y1_q  <= OpW'(yf_q);
      x1_q  <= OpW'(xf_q);
      y3_q  <= -$signed({16'd0, qf_q});
      x3_q  <= OpW'(nf_q);
      ya2_q <= OpW'(sf_q);
      xa2_q <= $signed({32'd0, rf_q});
      yb2_q <= -$signed({2'b00, a3q_q});
      xb2_q <= $signed({2'b00, a2h_q}) + $signed({a3n_q[46], a3n_q});
      rollg_q <= rollf_q;
    end
  end

  assign at_g = '{valid: vg_q, roll: rollg_q};

  logic signed [31:0] t1, t3, ta, tb;
  aik_atan2 #(.STAGES(CORDIC_STAGES)) u_at1 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .y_i(y1_q), .x_i(x1_q), .ang_o(t1)
  );
  aik_atan2 #(.STAGES(CORDIC_STAGES)) u_at3 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .y_i(y3_q), .x_i(x3_q), .ang_o(t3)
  );
  aik_atan2 #(.STAGES(CORDIC_STAGES)) u_ata (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .y_i(ya2_q), .x_i(xa2_q), .ang_o(ta)
  );
  aik_atan2 #(.STAGES(CORDIC_STAGES)) u_atb (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .y_i(yb2_q), .x_i(xb2_q), .ang_o(tb)
  );

  aik_delay #(.W($bits(at_side_t)), .DEPTH(AtLat)) u_at_side (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .d_i(at_g), .d_o(at_h)
  );

  // stage h: joint sums in fine units
  logic signed [FineW-1:0] t2_c;
  logic signed [FineW-1:0] t1h_q, t2h_q, eh_q, rlh_q;
  assign t2_c = FineW'(ta) - FineW'(tb);
  always_ff @(posedge clk_i) begin
    if (en) begin
      t1h_q <= FineW'(t1);
      t2h_q <= t2_c;
      eh_q  <= t2_c + FineW'(t3);
      rlh_q <= FineW'(t1) + (FineW'(at_h.roll) <<< 16);
    end
  end

  // stage i: round, saturate, output word
  logic signed [JointW-1:0] base_q, sh_q, el_q, rl_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      base_q <= to_out(t1h_q);
      sh_q   <= to_out(t2h_q);
      el_q   <= to_out(eh_q);
      rl_q   <= to_out(rlh_q);
    end
  end

  assign out_valid_o      = vi_q;
  assign base_joint_o     = base_q;
  assign shoulder_joint_o = sh_q;
  assign elbow_joint_o    = el_q;
  assign pitch_joint_o    = PitchFixed;
  assign roll_joint_o     = rl_q;

endmodule

// ===== rtl/core/aik_checker.sv =====
`timescale 1ns / 1ps

module aik_checker import aik_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [JointW-1:0] base_joint_o,
  input logic signed [JointW-1:0] shoulder_joint_o,
  input logic signed [JointW-1:0] pitch_joint_o,
  input logic signed [JointW-1:0] roll_joint_o
);

  // pipeline only holds when the output word is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall without a held output word");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(shoulder_joint_o)
      && $stable(roll_joint_o))
    else $error("held output word changed");

  a_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pitch_joint_o == PitchFixed)
    else $error("pitch joint not fixed");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> base_joint_o <= 17'sd46080 && base_joint_o >= -17'sd46080
      && shoulder_joint_o <= 17'sd46080 && shoulder_joint_o >= -17'sd46080)
    else $error("joint angle out of range");

endmodule

bind arm_inverse_kinematics aik_checker u_aik_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .base_joint_o     (base_joint_o),
  .shoulder_joint_o (shoulder_joint_o),
  .pitch_joint_o    (pitch_joint_o),
  .roll_joint_o     (roll_joint_o)
);
